FILE: hdl/dual_readout_energy_correction_top_defines.svh
// Assertion macros shared by the energy correction RTL.
`ifndef DUAL_READOUT_ENERGY_CORRECTION_TOP_DEFINES_SVH
`define DUAL_READOUT_ENERGY_CORRECTION_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DRC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DRC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/drc_pkg.sv
// Shared types and constants for the dual-readout energy correction block.
`default_nettype none
package drc_pkg;

	localparam int ACC_W = 32;
	localparam int NUM_W = 49;
	localparam int MAG_W = 48;
	localparam int DEN_W = 17;
	localparam int Q_W   = 40;
	localparam int CHI_W = 16;

	// Readout type codes.
	localparam logic [1:0] RT_SCINT  = 2'd0;
	localparam logic [1:0] RT_CHEREN = 2'd1;

	// Configuration register indexes.
	localparam logic REG_CHI_ECAL = 1'b0;
	localparam logic REG_CHI_HCAL = 1'b1;

	// Request to the shared divider.
	typedef struct packed {
		logic                    start;
		logic signed [NUM_W-1:0] num;
		logic [DEN_W-1:0]        den;
	} div_req_t;

	// Answer of the shared divider, already clamped to 40 bits.
	typedef struct packed {
		logic                  done;
		logic signed [Q_W-1:0] quo;
		logic                  sat;
	} div_rsp_t;

	// Saturating 32-bit add; the top bit of the result flags saturation.
	function automatic logic [ACC_W:0] sat_add(input logic [ACC_W-1:0] a,
			input logic [ACC_W-1:0] b);
		logic [ACC_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[ACC_W]) begin
			s = {1'b1, {ACC_W{1'b1}}};
		end
		return s;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/drc_div.sv
// Bit-serial signed divider for the correction, with 40-bit clamping.
`default_nettype none
module drc_div (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire drc_pkg::div_req_t req,
	output drc_pkg::div_rsp_t   rsp
);

	localparam int MW = drc_pkg::MAG_W;
	localparam int DW = drc_pkg::DEN_W;
	localparam int QW = drc_pkg::Q_W;

	logic          busy_q;
	logic          done_q;
	logic [5:0]    cnt_q;
	logic          neg_q;
	logic [MW-1:0] mag_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   trial;
	logic          ge;
	logic [MW-1:0] abs_num;

	assign abs_num = MW'(req.num[drc_pkg::NUM_W-1] ? -req.num : req.num);
	assign trial   = {rem_q, mag_q[MW-1]};
	assign ge      = trial >= {1'b0, den_q};

	// One quotient bit per cycle; the dividend shifts out as quotient bits shift in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				neg_q  <= req.num[drc_pkg::NUM_W-1];
				mag_q  <= abs_num;
				rem_q  <= '0;
				den_q  <= req.den;
			end else if (busy_q) begin
				rem_q <= ge ? DW'(trial - {1'b0, den_q}) : DW'(trial);
				mag_q <= {mag_q[MW-2:0], ge};
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(MW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Sign restore and clamp to the signed 40-bit range.
	always_comb begin
		rsp.done = done_q;
		rsp.sat  = 1'b0;
		if (neg_q) begin
			if (mag_q > (MW'(1) << (QW - 1))) begin
				rsp.quo = {1'b1, {(QW-1){1'b0}}};
				rsp.sat = 1'b1;
			end else begin
				rsp.quo = -QW'(mag_q);
			end
		end else begin
			if (mag_q >= (MW'(1) << (QW - 1))) begin
				rsp.quo = {1'b0, {(QW-1){1'b1}}};
				rsp.sat = 1'b1;
			end else begin
				rsp.quo = QW'(mag_q);
			end
		end
	end

endmodule
`default_nettype wire

FILE: hdl/dual_readout_energy_correction_top.sv
// Top level: hit accumulation, per-layer profile memory, correction and readout.
// Each hit is accepted, then its layer memory word goes through a read-modify-write.
// A new hit is taken only once the previous hit's layer update has been written back.
// The last hit then starts the correction (two 48-step serial divisions),
// then each layer word is read (S_RD) and held (S_HOLD) until the output takes it.
// Reset: asynchronous; then all NUM_LAYERS layer words are cleared before input is taken.
`default_nettype none
`include "dual_readout_energy_correction_top_defines.svh"
module dual_readout_energy_correction_top #(
	parameter int NUM_LAYERS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [15:0]        cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               hit_isolated,
	input  wire logic [1:0]         readout_type,
	input  wire logic [4:0]         depth_layer,
	input  wire logic signed [24:0] ecal_energy,
	input  wire logic signed [24:0] hcal_energy,
	input  wire logic               last_in_cluster,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [4:0]              layer_index,
	output logic [31:0]             layer_ecal_scint,
	output logic [31:0]             layer_ecal_cheren,
	output logic [31:0]             ecal_scint_total,
	output logic [31:0]             ecal_cheren_total,
	output logic [31:0]             hcal_scint_total,
	output logic [31:0]             hcal_cheren_total,
	output logic signed [39:0]      ecal_corrected,
	output logic signed [39:0]      hcal_corrected,
	output logic signed [39:0]      total_corrected,
	output logic                    saturated,
	output logic                    last_of_run
);

	localparam int AW = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
	localparam int AC = drc_pkg::ACC_W;
	localparam int QW = drc_pkg::Q_W;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_RMW, S_MUL_E, S_DIV_E, S_MUL_H, S_DIV_H, S_SUM, S_RD, S_HOLD
	} state_t;

	state_t state_q;

	localparam int CHI_LOCAL_W = drc_pkg::CHI_W;
	logic [CHI_LOCAL_W-1:0] chi_ecal_q, chi_hcal_q;

	logic [AC-1:0] es_q, ec_q, hs_q, hc_q;
	logic          saw_q, ovf_q, csat_q;
	logic [AW-1:0] k_q;
	logic [1:0]    rt_q;
	logic [23:0]   ee_q, he_q;
	logic          lv_q, last_q;
	logic [AW-1:0] addr_q;
	logic [47:0]   prod_q;
	logic          start_q;
	logic signed [QW-1:0] ecorr_q, hcorr_q, tcorr_q;

	// Layer profile memory: {cherenkov, scintillation} per layer.
	logic [2*AC-1:0] mem [NUM_LAYERS];
	logic [2*AC-1:0] rd_q;
	logic            mem_re, mem_we;
	logic [AW-1:0]   mem_raddr, mem_waddr;
	logic [2*AC-1:0] mem_wdata;

	logic in_acc, out_acc;
	logic is_s, is_c;
	logic [AC:0] es_n, ec_n, hs_n, hc_n, ls_n, lc_n;
	logic [AC-1:0] ee32, he32;
	logic signed [QW:0] tsum;

	drc_pkg::div_req_t dreq;
	drc_pkg::div_rsp_t drsp;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = state_q == S_HOLD;
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;

	// Saturating updates for the hit held in the modify stage.
	assign is_s = rt_q == drc_pkg::RT_SCINT;
	assign is_c = rt_q == drc_pkg::RT_CHEREN;
	assign ee32 = {8'd0, ee_q};
	assign he32 = {8'd0, he_q};
	assign es_n = drc_pkg::sat_add(es_q, is_s ? ee32 : '0);
	assign ec_n = drc_pkg::sat_add(ec_q, is_c ? ee32 : '0);
	assign hs_n = drc_pkg::sat_add(hs_q, is_s ? he32 : '0);
	assign hc_n = drc_pkg::sat_add(hc_q, is_c ? he32 : '0);
	assign ls_n = drc_pkg::sat_add(rd_q[AC-1:0], is_s ? ee32 : '0);
	assign lc_n = drc_pkg::sat_add(rd_q[2*AC-1:AC], is_c ? ee32 : '0);

	// Memory port control: hit update, readout with clear, and the reset sweep.
	always_comb begin
		mem_re    = in_acc || (state_q == S_RD);
		mem_raddr = (state_q == S_RD) ? k_q : AW'(depth_layer);
		mem_we    = (state_q == S_INIT) || (state_q == S_RD) || (state_q == S_RMW && lv_q);
		mem_waddr = (state_q == S_RMW) ? addr_q : k_q;
		mem_wdata = (state_q == S_RMW) ? {lc_n[AC-1:0], ls_n[AC-1:0]} : '0;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	// Shared divider request: (S * 2^16 - chi * C) / (2^16 - chi).
	always_comb begin
		dreq.start = start_q;
		if (state_q == S_DIV_H) begin
			dreq.num = $signed({1'b0, hs_q, 16'd0}) - $signed({1'b0, prod_q});
			dreq.den = 17'h10000 - {1'b0, chi_hcal_q};
		end else begin
			dreq.num = $signed({1'b0, es_q, 16'd0}) - $signed({1'b0, prod_q});
			dreq.den = 17'h10000 - {1'b0, chi_ecal_q};
		end
	end

	drc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign tsum = QW'(0) + {ecorr_q[QW-1], ecorr_q} + {hcorr_q[QW-1], hcorr_q};

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chi_ecal_q <= 16'd32768;
			chi_hcal_q <= 16'd32768;
		end else if (cfg_we) begin
			unique case (cfg_index)
				drc_pkg::REG_CHI_ECAL: chi_ecal_q <= cfg_wdata;
				drc_pkg::REG_CHI_HCAL: chi_hcal_q <= cfg_wdata;
			endcase
		end
	end

	// Sequencer with accumulators and correction results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			k_q     <= '0;
			es_q    <= '0;
			ec_q    <= '0;
			hs_q    <= '0;
			hc_q    <= '0;
			saw_q   <= 1'b0;
			ovf_q   <= 1'b0;
			csat_q  <= 1'b0;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					if (k_q == AW'(NUM_LAYERS - 1)) begin
						k_q     <= '0;
						state_q <= S_IDLE;
					end else begin
						k_q <= k_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						rt_q    <= readout_type;
						ee_q    <= ecal_energy[24] ? 24'd0 : ecal_energy[23:0];
						he_q    <= hcal_energy[24] ? 24'd0 : hcal_energy[23:0];
						lv_q    <= 32'(depth_layer) < NUM_LAYERS;
						addr_q  <= AW'(depth_layer);
						last_q  <= last_in_cluster;
						saw_q   <= saw_q || !hit_isolated;
						state_q <= S_RMW;
					end
				end
				S_RMW: begin
					es_q  <= es_n[AC-1:0];
					ec_q  <= ec_n[AC-1:0];
					hs_q  <= hs_n[AC-1:0];
					hc_q  <= hc_n[AC-1:0];
					ovf_q <= ovf_q || es_n[AC] || ec_n[AC] || hs_n[AC] || hc_n[AC]
						|| (lv_q && (ls_n[AC] || lc_n[AC]));
					state_q <= last_q ? S_MUL_E : S_IDLE;
				end
				S_MUL_E: begin
					prod_q  <= 48'(chi_ecal_q) * 48'(ec_q);
					start_q <= 1'b1;
					state_q <= S_DIV_E;
				end
				S_DIV_E: begin
					if (drsp.done) begin
						ecorr_q <= drsp.quo;
						csat_q  <= drsp.sat;
						state_q <= S_MUL_H;
					end
				end
				S_MUL_H: begin
					prod_q  <= 48'(chi_hcal_q) * 48'(hc_q);
					start_q <= 1'b1;
					state_q <= S_DIV_H;
				end
				S_DIV_H: begin
					if (drsp.done) begin
						hcorr_q <= drsp.quo;
						csat_q  <= csat_q || drsp.sat;
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					// Clamp the sum of the two corrected values to 40 bits.
					if (tsum[QW] != tsum[QW-1]) begin
						tcorr_q <= tsum[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
						csat_q  <= 1'b1;
					end else begin
						tcorr_q <= tsum[QW-1:0];
					end
					k_q     <= '0;
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_HOLD;
				end
				S_HOLD: begin
					if (out_acc) begin
						if (k_q == AW'(NUM_LAYERS - 1)) begin
							k_q     <= '0;
							es_q    <= '0;
							ec_q    <= '0;
							hs_q    <= '0;
							hc_q    <= '0;
							saw_q   <= 1'b0;
							ovf_q   <= 1'b0;
							csat_q  <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + AW'(1);
							state_q <= S_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result word, zeroed when the cluster held no regular hit.
	assign layer_index       = 5'(k_q);
	assign last_of_run       = k_q == AW'(NUM_LAYERS - 1);
	assign layer_ecal_scint  = saw_q ? rd_q[AC-1:0] : '0;
	assign layer_ecal_cheren = saw_q ? rd_q[2*AC-1:AC] : '0;
	assign ecal_scint_total  = saw_q ? es_q : '0;
	assign ecal_cheren_total = saw_q ? ec_q : '0;
	assign hcal_scint_total  = saw_q ? hs_q : '0;
	assign hcal_cheren_total = saw_q ? hc_q : '0;
	assign ecal_corrected    = saw_q ? ecorr_q : '0;
	assign hcal_corrected    = saw_q ? hcorr_q : '0;
	assign total_corrected   = saw_q ? tcorr_q : '0;
	assign saturated         = saw_q && (ovf_q || csat_q);

	`DRC_ASSERT_NEXT(a_hit_interlock, in_acc, !in_ready, "input taken during layer update")
	`DRC_ASSERT_NOW(a_no_in_on_out, out_valid, !in_ready, "input open during readout")
	`DRC_ASSERT_NOW(a_div_done_state, drsp.done, state_q == S_DIV_E || state_q == S_DIV_H,
		"divider finished outside a division step")
	`DRC_ASSERT_NEXT(a_run_end_idle, out_acc && last_of_run, in_ready,
		"block not idle after final layer word")

endmodule
`default_nettype wire

FILE: verif/tb_dual_readout_energy_correction_top.sv
// Self-checking testbench for the dual-readout energy correction block.
`timescale 1ns / 100ps
`default_nettype none

// One readout word of a cluster.
typedef struct packed {
	logic [4:0]         idx;
	logic [31:0]        lay_s;
	logic [31:0]        lay_c;
	logic [31:0]        es;
	logic [31:0]        ec;
	logic [31:0]        hs;
	logic [31:0]        hc;
	logic signed [39:0] ecor;
	logic signed [39:0] hcor;
	logic signed [39:0] tcor;
	logic               sat;
	logic               last;
} layer_word_t;

// Predicts the per-layer readout of each cluster and checks the block's words.
class cluster_scoreboard;
	bit [15:0] chi_e, chi_h;
	bit [31:0] es, ec, hs, hc;
	bit [31:0] lay_s[32], lay_c[32];
	bit regular_seen, ovf;
	layer_word_t pending_words[$];
	int errors;

	function new();
		chi_e = 16'd32768;
		chi_h = 16'd32768;
		errors = 0;
		clear();
	endfunction

	function void clear();
		es = 0; ec = 0; hs = 0; hc = 0;
		foreach (lay_s[k]) begin
			lay_s[k] = 0;
			lay_c[k] = 0;
		end
		regular_seen = 0;
		ovf = 0;
	endfunction

	function bit [31:0] acc_add(bit [31:0] a, bit [31:0] b);
		bit [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[32]) begin
			ovf = 1;
			return 32'hFFFF_FFFF;
		end
		return s[31:0];
	endfunction

	function longint clip40(longint v, ref bit flag);
		if (v > 64'sd549755813887) begin
			flag = 1;
			return 64'sd549755813887;
		end
		if (v < -64'sd549755813888) begin
			flag = 1;
			return -64'sd549755813888;
		end
		return v;
	endfunction

	function longint corrected(bit [31:0] s, bit [31:0] c, bit [15:0] chi, ref bit flag);
		longint num, den;
		num = longint'({s, 16'h0}) - longint'(chi) * longint'(c);
		den = 65536 - longint'(chi);
		return clip40(num / den, flag);
	endfunction

	// Notes one accepted hit word and queues the readout it triggers.
	function void note_hit(bit iso, bit [1:0] rt, bit [4:0] layer,
			logic signed [24:0] ee_raw, logic signed [24:0] he_raw, bit last);
		bit [31:0] ee, he;
		bit flag;
		longint e_c, h_c, t_c;
		layer_word_t w;
		ee = (ee_raw > 0) ? 32'(ee_raw) : 0;
		he = (he_raw > 0) ? 32'(he_raw) : 0;
		if (!iso) regular_seen = 1;
		if (rt == drc_pkg::RT_SCINT) begin
			if (ee != 0) begin
				es = acc_add(es, ee);
				lay_s[layer] = acc_add(lay_s[layer], ee);
			end
			if (he != 0) hs = acc_add(hs, he);
		end else if (rt == drc_pkg::RT_CHEREN) begin
			if (ee != 0) begin
				ec = acc_add(ec, ee);
				lay_c[layer] = acc_add(lay_c[layer], ee);
			end
			if (he != 0) hc = acc_add(hc, he);
		end
		if (!last) return;
		flag = ovf;
		e_c = 0; h_c = 0; t_c = 0;
		if (regular_seen) begin
			e_c = corrected(es, ec, chi_e, flag);
			h_c = corrected(hs, hc, chi_h, flag);
			t_c = clip40(e_c + h_c, flag);
		end
		for (int k = 0; k < 32; k++) begin
			w = '0;
			w.idx = 5'(k);
			if (regular_seen) begin
				w.lay_s = lay_s[k]; w.lay_c = lay_c[k];
				w.es = es; w.ec = ec; w.hs = hs; w.hc = hc;
				w.ecor = 40'(e_c); w.hcor = 40'(h_c); w.tcor = 40'(t_c);
				w.sat = flag;
			end
			w.last = (k == 31);
			pending_words.push_back(w);
		end
		clear();
	endfunction

	// Compares one accepted readout word with the oldest expectation.
	function void check_word(layer_word_t got);
		layer_word_t x;
		if (pending_words.size() == 0) begin
			$error("unexpected readout word, layer %0d", got.idx);
			errors++;
			return;
		end
		x = pending_words.pop_front();
		if (got.idx !== x.idx) begin
			$error("layer_index exp %0d got %0d", x.idx, got.idx); errors++; end
		if (got.lay_s !== x.lay_s) begin
			$error("layer_ecal_scint exp %h got %h", x.lay_s, got.lay_s); errors++; end
		if (got.lay_c !== x.lay_c) begin
			$error("layer_ecal_cheren exp %h got %h", x.lay_c, got.lay_c); errors++; end
		if (got.es !== x.es) begin
			$error("ecal_scint_total exp %h got %h", x.es, got.es); errors++; end
		if (got.ec !== x.ec) begin
			$error("ecal_cheren_total exp %h got %h", x.ec, got.ec); errors++; end
		if (got.hs !== x.hs) begin
			$error("hcal_scint_total exp %h got %h", x.hs, got.hs); errors++; end
		if (got.hc !== x.hc) begin
			$error("hcal_cheren_total exp %h got %h", x.hc, got.hc); errors++; end
		if (got.ecor !== x.ecor) begin
			$error("ecal_corrected exp %0d got %0d", x.ecor, got.ecor); errors++; end
		if (got.hcor !== x.hcor) begin
			$error("hcal_corrected exp %0d got %0d", x.hcor, got.hcor); errors++; end
		if (got.tcor !== x.tcor) begin
			$error("total_corrected exp %0d got %0d", x.tcor, got.tcor); errors++; end
		if (got.sat !== x.sat) begin
			$error("saturated exp %0d got %0d", x.sat, got.sat); errors++; end
		if (got.last !== x.last) begin
			$error("last_of_run exp %0d got %0d", x.last, got.last); errors++; end
	endfunction
endclass

module tb_dual_readout_energy_correction_top;

	localparam int CYCLE_LIMIT = 600000;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic cfg_index = drc_pkg::REG_CHI_ECAL;
	logic [15:0] cfg_wdata = '0;
	logic in_valid = 0;
	logic in_ready;
	logic hit_isolated = 0;
	logic [1:0] readout_type = '0;
	logic [4:0] depth_layer = '0;
	logic signed [24:0] ecal_energy = '0;
	logic signed [24:0] hcal_energy = '0;
	logic last_in_cluster = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [4:0] layer_index;
	logic [31:0] layer_ecal_scint, layer_ecal_cheren;
	logic [31:0] ecal_scint_total, ecal_cheren_total, hcal_scint_total, hcal_cheren_total;
	logic signed [39:0] ecal_corrected, hcal_corrected, total_corrected;
	logic saturated, last_of_run;

	cluster_scoreboard sb = new();
	int cycles = 0;
	int burst_left = 0;
	bit long_hold = 0;

	dual_readout_energy_correction_top dut (.*);

	// Clock with 10 ns period.
	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Run watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Output side: check every accepted word.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			sb.check_word('{layer_index, layer_ecal_scint, layer_ecal_cheren,
				ecal_scint_total, ecal_cheren_total, hcal_scint_total, hcal_cheren_total,
				ecal_corrected, hcal_corrected, total_corrected, saturated, last_of_run});
		end
	end

	// Receiver stalls on its own pattern, with one long hold-off.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ready <= 0;
				repeat (400) @(negedge clk);
				long_hold = 0;
			end
			if (cycles % 300 < 100) out_ready <= 1;
			else out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	task automatic write_reg(logic idx, logic [15:0] val);
		in_valid <= 0;
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 0;
		if (idx == drc_pkg::REG_CHI_ECAL) sb.chi_e = val;
		else sb.chi_h = val;
	endtask

	// Offers one hit word at a falling edge and waits for its acceptance.
	// Valid stays high afterwards; a gap or an idle phase drops it.
	task automatic send_hit(bit iso, bit [1:0] rt, bit [4:0] layer,
			logic signed [24:0] ee, logic signed [24:0] he, bit last);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 2) != 0) begin
				in_valid <= 0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1;
		hit_isolated <= iso;
		readout_type <= rt;
		depth_layer <= layer;
		ecal_energy <= ee;
		hcal_energy <= he;
		last_in_cluster <= last;
		do @(posedge clk); while (!in_ready);
		sb.note_hit(iso, rt, layer, ee, he, last);
		@(negedge clk);
	endtask

	function automatic logic signed [24:0] rand_energy();
		case ($urandom_range(0, 9))
			0: return 25'sh0FFFFFF;
			1: return -25'sd1;
			2: return 25'sh1000000;
			3: return '0;
			4: return 25'($urandom);
			default: return 25'($urandom_range(1, 25'h0FFFFFF));
		endcase
	endfunction

	task automatic wait_drained();
		in_valid <= 0;
		while (sb.pending_words.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// Random clusters of well-formed hits with noise mixed in.
	task automatic random_clusters(int n_hits);
		int len;
		while (n_hits > 0) begin
			len = $urandom_range(1, 10);
			for (int i = 0; i < len; i++) begin
				send_hit($urandom_range(0, 7) == 0, ($urandom_range(0, 7) == 0) ?
					2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1)),
					5'($urandom), rand_energy(), rand_energy(), i == len - 1);
				n_hits--;
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// Directed: every readout type, energy extremes, isolated-only cluster.
		send_hit(0, drc_pkg::RT_SCINT, 0, 25'sh0FFFFFF, 25'sh0FFFFFF, 0);
		send_hit(0, drc_pkg::RT_CHEREN, 31, 25'sh0FFFFFF, 25'sh0FFFFFF, 0);
		send_hit(0, 2'd2, 5, 25'sh0FFFFFF, 25'sh0FFFFFF, 0);
		send_hit(0, 2'd3, 7, -25'sd1, 25'sh1000000, 0);
		send_hit(0, drc_pkg::RT_SCINT, 3, 25'sh1000000, -25'sd5, 0);
		send_hit(0, drc_pkg::RT_SCINT, 3, 25'sd1, 25'sd0, 1);
		wait_drained();
		send_hit(1, drc_pkg::RT_SCINT, 1, 25'sd1000, 25'sd2000, 0);
		send_hit(1, drc_pkg::RT_CHEREN, 2, 25'sd1000, 25'sd2000, 1);
		wait_drained();
		// Mostly Cherenkov gives a negative ECAL result; ECAL chi near one to push saturation.
		write_reg(drc_pkg::REG_CHI_ECAL, 16'hFFFF);
		write_reg(drc_pkg::REG_CHI_HCAL, 16'd1);
		for (int i = 0; i < 8; i++)
			send_hit(0, drc_pkg::RT_CHEREN, 5'(i), 25'sh0FFFFFF, 25'sh0FFFFFF, 0);
		send_hit(0, drc_pkg::RT_SCINT, 9, 25'sd3, 25'sd7, 1);
		wait_drained();
		// Drive the HCAL corrected value into saturation.
		for (int i = 0; i < 6; i++)
			send_hit(0, drc_pkg::RT_SCINT, 4, 25'sh0FFFFFF, 25'sh0FFFFFF, 0);
		write_reg(drc_pkg::REG_CHI_ECAL, 16'd1);
		write_reg(drc_pkg::REG_CHI_HCAL, 16'hFFFF);
		send_hit(0, drc_pkg::RT_SCINT, 4, 25'sh0FFFFFF, 25'sh0FFFFFF, 1);
		wait_drained();

		// Random with several chi settings; long output hold-off in one phase.
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(drc_pkg::REG_CHI_ECAL, 16'($urandom_range(1, 65535)));
			write_reg(drc_pkg::REG_CHI_HCAL, 16'($urandom_range(1, 65535)));
			if (ph == 1) long_hold = 1;
			random_clusters(40);
			wait_drained();
		end

		if (sb.errors == 0 && sb.pending_words.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

`default_nettype wire
